// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the presence fusion rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: src/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// shared types and constants of the presence sensor fusion core
// ----------------------------------------------------------------------------
package psf_pkg;

	// number of sensor slots the core may examine
	localparam int MAX_SENSORS = 4;

	// field widths of one request and one result
	localparam int STATES_W = 8;
	localparam int ENABLE_W = 4;
	localparam int TIME_W   = 32;
	localparam int FUSED_W  = 2;

	// one lane per enable bit, lanes beyond the clamp stay idle
	localparam int NUM_LANES  = ENABLE_W;

	// stream data widths, padded to whole bytes
	localparam int IN_DATA_W  = ((STATES_W + ENABLE_W + TIME_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((FUSED_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int POLICY_W   = 2;
	localparam int SLOTS_W    = 3;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAULT_POLICY   = 2'd0,
		REG_EMPTY_DELAY    = 2'd1,
		REG_SENSORS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [POLICY_W-1:0] {
		FP_HOLD      = 2'd0,
		FP_OCCUPIED  = 2'd1,
		FP_IGNORE    = 2'd2,
		FP_HOLD_ALT  = 2'd3
	} fault_policy_t;

	typedef enum logic [1:0] {
		SC_ABSENT     = 2'd0,
		SC_PRESENT    = 2'd1,
		SC_UNKNOWN    = 2'd2,
		SC_ABSENT_ALT = 2'd3
	} sensor_code_t;

	typedef enum logic [FUSED_W-1:0] {
		FUSED_ABSENT  = 2'd0,
		FUSED_PRESENT = 2'd1,
		FUSED_UNKNOWN = 2'd2
	} fused_state_t;

	// live configuration seen by the datapath
	typedef struct packed {
		logic [POLICY_W-1:0] fault_policy;
		logic [TIME_W-1:0]   empty_delay;
		logic [SLOTS_W-1:0]  sensors_in_use;
	} cfg_t;

	// reduction of all lanes for one sample
	typedef struct packed {
		logic any_considered;
		logic present_hit;
		logic hold_hit;
	} summary_t;

endpackage

// File: src/psf_eval.sv
// ----------------------------------------------------------------------------
// psf_eval
// per-lane classification of one sample and or-reduction across lanes
// ----------------------------------------------------------------------------
module psf_eval #(
	parameter int MAX_SENSORS = psf_pkg::MAX_SENSORS
) (
	input  logic [psf_pkg::STATES_W-1:0] sensor_states,
	input  logic [psf_pkg::ENABLE_W-1:0] enable_mask,
	input  psf_pkg::cfg_t                cfg,
	output psf_pkg::summary_t            summary
);
	import psf_pkg::*;

	// lanes past the input fields read as disabled
	localparam int SLOT_CAP = (MAX_SENSORS < NUM_LANES) ? MAX_SENSORS : NUM_LANES;

	logic [SLOTS_W-1:0] slots;

	// clamp the slot count to what the core supports
	assign slots = (cfg.sensors_in_use > SLOTS_W'(SLOT_CAP)) ?
		SLOTS_W'(SLOT_CAP) : cfg.sensors_in_use;

	always_comb begin
		logic       used;
		logic [1:0] st;
		summary = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			used = (SLOTS_W'(i) < slots) && enable_mask[i];
			st   = sensor_states[2*i +: 2];
			if (used) begin
				case (st)
					SC_PRESENT: begin
						summary.present_hit    = 1'b1;
						summary.any_considered = 1'b1;
					end
					SC_UNKNOWN: begin
						case (cfg.fault_policy)
							FP_OCCUPIED: begin
								summary.present_hit    = 1'b1;
								summary.any_considered = 1'b1;
							end
							FP_IGNORE: begin
							end
							default: begin
								summary.hold_hit       = 1'b1;
								summary.any_considered = 1'b1;
							end
						endcase
					end
					default: begin
						summary.any_considered = 1'b1;
					end
				endcase
			end
		end
	end

endmodule

// File: src/psf_timer.sv
// ----------------------------------------------------------------------------
// psf_timer
// empty countdown state and the fused decision for one sample
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psf_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  psf_pkg::summary_t           summary,
	input  logic [psf_pkg::TIME_W-1:0]  now_ms,
	input  logic [psf_pkg::TIME_W-1:0]  empty_delay,
	output psf_pkg::fused_state_t       fused_state
);
	import psf_pkg::*;

	logic              countdown_active_q;
	logic [TIME_W-1:0] absent_since_q;
	logic              quiet_all;
	logic [TIME_W-1:0] base;
	logic [TIME_W-1:0] elapsed;
	logic              active_next;

	assign quiet_all = summary.any_considered && !summary.present_hit &&
		!summary.hold_hit;

	// a fresh countdown starts at now, so elapsed is zero on its first sample
	assign base    = countdown_active_q ? absent_since_q : now_ms;
	assign elapsed = now_ms - base;

	always_comb begin
		active_next = 1'b0;
		fused_state = FUSED_PRESENT;
		if (!summary.any_considered) begin
			fused_state = FUSED_UNKNOWN;
		end else if (quiet_all) begin
			active_next = 1'b1;
			fused_state = (elapsed >= empty_delay) ? FUSED_ABSENT : FUSED_PRESENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_active_q <= 1'b0;
			absent_since_q     <= '0;
		end else if (fire) begin
			countdown_active_q <= active_next;
			if (quiet_all && !countdown_active_q) begin
				absent_since_q <= now_ms;
			end
		end
	end

	`ASSERT_PROP(a_start_stamp, clk, arst_n,
		$rose(countdown_active_q) |-> ($past(fire) && absent_since_q == $past(now_ms)),
		"countdown started without stamping the sample time")

	`ASSERT_PROP(a_absent_keeps_countdown, clk, arst_n,
		(fire && fused_state == FUSED_ABSENT) |=> countdown_active_q,
		"absent decision left no running countdown")

	`ASSERT_NEVER(a_unknown_with_present, clk, arst_n,
		fire && fused_state == FUSED_UNKNOWN && summary.present_hit,
		"unknown result while a sensor reports present")

endmodule

// File: src/presence_sensor_fusion_core.sv
// ----------------------------------------------------------------------------
// presence_sensor_fusion_core
// or-rule fusion of occupancy sensors with a delayed empty decision
// ----------------------------------------------------------------------------
// path: an accepted request passes the input register, then the result
//   register, on its way to the output stream
// throughput: one request per cycle while the output side keeps up; the lane
//   reduction and one 32-bit subtract-compare sit between the input and result registers
// reset: clears both valid flags, the empty countdown and the configuration
//   (fault policy 0, empty delay 0, two slots in use)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module presence_sensor_fusion_core #(
	parameter int MAX_SENSORS = psf_pkg::MAX_SENSORS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] sensor_states, [11:8] enable_mask, [43:12] now_ms, rest zero
	input  logic [psf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] fused_state, rest zero
	output logic [psf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psf_pkg::*;

	// configuration registers
	logic [POLICY_W-1:0] fault_policy_q;
	logic [TIME_W-1:0]   empty_delay_q;
	logic [SLOTS_W-1:0]  sensors_in_use_q;
	cfg_t                cfg;

	// input register
	logic                valid_s1;
	logic [STATES_W-1:0] states_s1;
	logic [ENABLE_W-1:0] enables_s1;
	logic [TIME_W-1:0]   now_s1;

	// result register
	logic                valid_s2;
	logic [FUSED_W-1:0]  fused_s2;

	// handshake
	logic          in_fire;
	logic          out_free;
	logic          adv_s1;
	summary_t      summary;
	fused_state_t  fused_state;

	// ---------------------------------------------------------------------
	// configuration port, always ready; unknown indexes are dropped
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_policy_q   <= FP_HOLD;
			empty_delay_q    <= '0;
			sensors_in_use_q <= SLOTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FAULT_POLICY:   fault_policy_q   <= cfg_data[POLICY_W-1:0];
				REG_EMPTY_DELAY:    empty_delay_q    <= cfg_data[TIME_W-1:0];
				REG_SENSORS_IN_USE: sensors_in_use_q <= cfg_data[SLOTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.fault_policy   = fault_policy_q;
	assign cfg.empty_delay    = empty_delay_q;
	assign cfg.sensors_in_use = sensors_in_use_q;

	// ---------------------------------------------------------------------
	// pipeline control: the result register frees up when empty or taken,
	// so a new request enters every cycle the output side keeps up
	// ---------------------------------------------------------------------
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			states_s1  <= s_axis_tdata[STATES_W-1:0];
			enables_s1 <= s_axis_tdata[STATES_W +: ENABLE_W];
			now_s1     <= s_axis_tdata[STATES_W+ENABLE_W +: TIME_W];
		end
	end

	// ---------------------------------------------------------------------
	// evaluation: lane reduction, then countdown and decision; the
	// countdown state moves only when the sample leaves stage one
	// ---------------------------------------------------------------------
	psf_eval #(
		.MAX_SENSORS (MAX_SENSORS)
	) u_eval (
		.sensor_states (states_s1),
		.enable_mask   (enables_s1),
		.cfg           (cfg),
		.summary       (summary)
	);

	psf_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv_s1),
		.summary     (summary),
		.now_ms      (now_s1),
		.empty_delay (cfg.empty_delay),
		.fused_state (fused_state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fused_s2 <= fused_state;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W-FUSED_W){1'b0}}, fused_s2};

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	`ASSERT_PROP(a_adv_fills_s2, clk, arst_n,
		adv_s1 |=> valid_s2,
		"sample left stage one but no result was registered")

	`ASSERT_PROP(a_full_blocks_input, clk, arst_n,
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready,
		"input accepted while both stages are full and stalled")

	`ASSERT_NEVER(a_no_bad_code, clk, arst_n,
		valid_s2 && fused_s2 == 2'd3,
		"result register holds an undefined occupancy code")

endmodule

// File: tb/presence_sensor_fusion_core_tb.sv
// ----------------------------------------------------------------------------
// presence_sensor_fusion_core_tb
// checks the or-rule presence fusion core against a cycle-free predictor:
// directed requests first, then random sensor walks under varied settings,
// with bursty requests, result back-pressure and long receiver hold-offs
// ----------------------------------------------------------------------------
module presence_sensor_fusion_core_tb;

	import psf_pkg::*;

	// spare register index, the core must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;

	// one sensor request, last field in the lowest bits
	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [ENABLE_W-1:0] enable_mask;
		logic [STATES_W-1:0] sensor_states;
	} sensor_sample_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [7:0] sensor_states, [11:8] enable_mask, [43:12] now_ms, rest zero
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [1:0] fused_state, rest zero
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// requests waiting for the driver and results waiting for the core
	sensor_sample_t pending_samples[$];
	fused_state_t   fused_expected[$];

	// mirror of the core configuration and of its empty countdown
	fault_policy_t      cfg_policy = FP_HOLD;
	logic [TIME_W-1:0]  cfg_delay = '0;
	logic [SLOTS_W-1:0] cfg_slots = SLOTS_RESET;
	bit                 countdown_on = 1'b0;
	logic [TIME_W-1:0]  quiet_since = '0;

	// traffic shaping, set per phase by the stimulus process
	int tx_gap_max = 0;
	int rx_mode = 0;
	int holds_asked = 0;

	int mismatches = 0;

	// random sensor walk
	logic [TIME_W-1:0]   walk_ms;
	logic [ENABLE_W-1:0] walk_enables;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	presence_sensor_fusion_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// fused state of one request, advances the countdown mirror
	function automatic fused_state_t predict_fused(sensor_sample_t smp);
		int           slots;
		int           i;
		int           considered;
		int           absent_cnt;
		bit           present_hit;
		bit           hold_hit;
		sensor_code_t code;
		logic [TIME_W-1:0] elapsed;
		fused_state_t res;

		slots = (cfg_slots > MAX_SENSORS) ? MAX_SENSORS : int'(cfg_slots);
		considered = 0;
		absent_cnt = 0;
		present_hit = 1'b0;
		hold_hit = 1'b0;
		for (i = 0; i < slots; i++) begin
			if (!smp.enable_mask[i])
				continue;
			code = sensor_code_t'(smp.sensor_states[2*i +: 2]);
			case (code)
				SC_UNKNOWN: begin
					// faulted sensor handling follows the policy
					if (cfg_policy == FP_OCCUPIED) begin
						present_hit = 1'b1;
						considered++;
					end else if (cfg_policy != FP_IGNORE) begin
						hold_hit = 1'b1;
						considered++;
					end
				end
				SC_PRESENT: begin
					present_hit = 1'b1;
					considered++;
				end
				default: begin
					// code three reads as absent
					considered++;
					absent_cnt++;
				end
			endcase
		end

		if (considered == 0) begin
			countdown_on = 1'b0;
			res = FUSED_UNKNOWN;
		end else if (present_hit) begin
			countdown_on = 1'b0;
			res = FUSED_PRESENT;
		end else if (!hold_hit && absent_cnt == considered) begin
			if (!countdown_on) begin
				countdown_on = 1'b1;
				quiet_since = smp.now_ms;
			end
			// wrapping difference
			elapsed = smp.now_ms - quiet_since;
			res = (elapsed >= cfg_delay) ? FUSED_ABSENT : FUSED_PRESENT;
		end else begin
			countdown_on = 1'b0;
			res = FUSED_PRESENT;
		end
		return res;
	endfunction

	// request driver: bursts of random length with random gaps between them
	sensor_sample_t tx_sample;
	int             tx_burst_left = 0;
	int             tx_gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			// a request taken at this edge gets its prediction now
			if (s_axis_tvalid && s_axis_tready)
				fused_expected.push_back(predict_fused(tx_sample));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					tx_sample = pending_samples.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_DATA_W'(tx_sample);
					if (tx_burst_left > 0) begin
						tx_burst_left--;
					end else begin
						// end of burst, pick the next gap and burst length
						tx_burst_left = $urandom_range(1, 24);
						tx_gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own stall pattern and long hold-offs
	int rx_hold_left = 0;
	int holds_granted = 0;
	int rx_tick = 0;
	fused_state_t fused_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_tick++;
			if (m_axis_tvalid && m_axis_tready) begin
				if (fused_expected.size() == 0) begin
					$error("unexpected result, fused_state actual %0d", m_axis_tdata[1:0]);
					mismatches++;
				end else begin
					fused_want = fused_expected.pop_front();
					if (m_axis_tdata[FUSED_W-1:0] !== fused_want) begin
						$error("fused_state mismatch: expected %0d, actual %0d",
							fused_want, m_axis_tdata[FUSED_W-1:0]);
						mismatches++;
					end
					if (m_axis_tdata[OUT_DATA_W-1:FUSED_W] !== '0) begin
						$error("tdata padding mismatch: expected 0, actual %0h",
							m_axis_tdata[OUT_DATA_W-1:FUSED_W]);
						mismatches++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_granted != holds_asked) begin
				// long hold-off so the core fills up and stalls its input
				holds_granted++;
				rx_hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 99) < 70);
					default: m_axis_tready <= ((rx_tick % 11) >= 4);
				endcase
			end
		end
	end

	// one register write on the configuration channel, mirrored on handshake
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_FAULT_POLICY:   cfg_policy = fault_policy_t'(val[POLICY_W-1:0]);
			REG_EMPTY_DELAY:    cfg_delay = val[TIME_W-1:0];
			REG_SENSORS_IN_USE: cfg_slots = val[SLOTS_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input fault_policy_t pol, input logic [TIME_W-1:0] dly,
		input logic [SLOTS_W-1:0] slots);
		write_reg(REG_FAULT_POLICY, CFG_DATA_W'(pol));
		write_reg(REG_EMPTY_DELAY, dly);
		write_reg(REG_SENSORS_IN_USE, CFG_DATA_W'(slots));
	endtask

	task automatic add_sample(input logic [STATES_W-1:0] st, input logic [ENABLE_W-1:0] en,
		input logic [TIME_W-1:0] now);
		pending_samples.push_back('{now_ms: now, enable_mask: en, sensor_states: st});
	endtask

	// wait until every request is taken and every result has come back
	task automatic drain();
		@(negedge clk);
		while (pending_samples.size() != 0 || s_axis_tvalid || fused_expected.size() != 0)
			@(negedge clk);
	endtask

	// mostly a well-formed walk of mostly absent sensors, some noise
	task automatic add_random_sample();
		logic [STATES_W-1:0] st;
		int i;
		int r;

		if ($urandom_range(0, 99) < 15) begin
			add_sample(STATES_W'($urandom_range(0, 255)), ENABLE_W'($urandom_range(0, 15)),
				$urandom());
		end else begin
			walk_ms += $urandom_range(0, 40);
			if ($urandom_range(0, 19) == 0)
				walk_enables = ENABLE_W'($urandom_range(0, 15));
			for (i = 0; i < MAX_SENSORS; i++)
				st[2*i +: 2] = $urandom_range(0, 1) ? SC_ABSENT : SC_ABSENT_ALT;
			r = $urandom_range(0, 99);
			if (r < 12)
				st[2*$urandom_range(0, MAX_SENSORS-1) +: 2] = SC_PRESENT;
			else if (r < 22)
				st[2*$urandom_range(0, MAX_SENSORS-1) +: 2] = SC_UNKNOWN;
			add_sample(st, walk_enables, walk_ms);
		end
	endtask

	initial begin
		int p;
		int k;
		logic [TIME_W-1:0]  dly;
		logic [SLOTS_W-1:0] slots;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: hold policy, no delay, two slots, no idling
		add_sample(8'h00, 4'hF, 32'h0000_0000);     // countdown start, absent at once
		add_sample(8'hFF, 4'hF, 32'hFFFF_FFFF);     // code three reads absent
		add_sample(8'h55, 4'hF, 32'h0000_0001);     // present
		add_sample(8'hAA, 4'hF, 32'h0000_0002);     // blocking fault
		add_sample(8'h00, 4'h0, 32'h0000_0003);     // nothing enabled
		add_sample(8'h55, 4'hC, 32'h0000_0004);     // only slots past the limit enabled
		add_sample(8'h01, 4'h2, 32'h0000_0005);     // one sensor considered
		drain();

		// fault means occupied, slot count clamped, delay crossing the wrap
		configure(FP_OCCUPIED, 32'd100, 3'd7);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		add_sample(8'h80, 4'hF, 32'd1000);          // fault on the last slot
		add_sample(8'h00, 4'hF, 32'd1000);          // within the delay
		add_sample(8'hFF, 4'hF, 32'd1099);
		add_sample(8'h33, 4'hF, 32'd1100);          // delay reached
		add_sample(8'h04, 4'hF, 32'hFFFF_FFF0);
		add_sample(8'h00, 4'hF, 32'hFFFF_FFF0);
		add_sample(8'h00, 4'hF, 32'h0000_0054);     // elapsed across the wrap
		drain();

		// faults ignored, largest delay
		configure(FP_IGNORE, 32'hFFFF_FFFF, 3'd4);
		add_sample(8'hAA, 4'hF, 32'd5);             // every sensor ignored
		add_sample(8'h02, 4'hF, 32'd7);
		add_sample(8'h00, 4'hF, 32'd6);             // one step back is the full span
		add_sample(8'h10, 4'hF, 32'd6);
		add_sample(8'h00, 4'h8, 32'd9);
		drain();

		// alternate hold code, no slots at all
		configure(FP_HOLD_ALT, 32'd0, 3'd0);
		add_sample(8'h00, 4'hF, 32'd0);
		add_sample(8'h55, 4'hF, 32'd1);
		drain();
		write_reg(REG_SENSORS_IN_USE, 32'd3);
		add_sample(8'h20, 4'hF, 32'd2);             // blocking fault on slot two
		add_sample(8'hC0, 4'h7, 32'd3);
		drain();

		// random phases under random settings
		for (p = 0; p < 7; p++) begin
			case ($urandom_range(0, 4))
				0: dly = 32'd0;
				1: dly = $urandom_range(1, 20);
				2: dly = $urandom_range(20, 300);
				3: dly = 32'hFFFF_FFFF;
				default: dly = $urandom();
			endcase
			slots = ($urandom_range(0, 9) < 7) ? SLOTS_W'($urandom_range(2, 4)) :
				SLOTS_W'($urandom_range(0, 7));
			configure(fault_policy_t'($urandom_range(0, 3)), dly, slots);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, $urandom());
			@(negedge clk);
			tx_gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
			rx_mode = p % 3;
			walk_ms = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 2000);
			walk_enables = ENABLE_W'($urandom_range(1, 15));
			for (k = 0; k < 100; k++) begin
				add_random_sample();
				if (p == 3 && k == 49)
					drain();                      // sender pauses for every result
			end
			if (p == 1 || p == 4)
				holds_asked++;
			drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && fused_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#3200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
